/* sv/mbmf_pkg.sv */
// shared types and codes for the masked box mean filter
package mbmf_pkg;

  localparam int unsigned SampleW = 16;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_FLUSH  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_MISSING = 2'd2,
    CFG_BAD     = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LAST,
    ST_DIV,
    ST_PUT
  } state_e;

  typedef struct packed {
    logic               action;
    logic [SampleW-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SampleW-1:0] smoothed;
    logic               frame_end;
  } out_item_t;

endpackage

/* sv/mbmf_div_cell.sv */
// one restoring division step, registered; cells chain into a divider
module mbmf_div_cell #(
  parameter int unsigned NUM_W = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [NUM_W-1:0]          rem_i,
  input  logic [mbmf_pkg::SampleW-1:0] word_i,
  input  logic [NUM_W-1:0]          num_i,
  output logic                      valid_o,
  output logic [NUM_W-1:0]          rem_o,
  output logic [mbmf_pkg::SampleW-1:0] word_o,
  output logic [NUM_W-1:0]          num_o
);
  import mbmf_pkg::*;

  logic [NUM_W:0]     cat;
  logic               ge;
  logic [NUM_W-1:0]   rem_d;
  logic [SampleW-1:0] word_d;

  always_comb begin
    cat    = {rem_i, word_i[SampleW-1]};
    ge     = (cat >= {1'b0, num_i});
    rem_d  = ge ? NUM_W'(cat - {1'b0, num_i}) : NUM_W'(cat);
    // dividend bits shift out at the top, quotient bits shift in at the bottom
    word_d = {word_i[SampleW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o  <= rem_d;
    word_o <= word_d;
    num_o  <= num_i;
  end

endmodule

/* sv/masked_box_mean_filter.sv */
// Throughput: one item every cycle when no result is due. A sample that releases a result
// holds the input stalled until the result is loaded for output, at a pace set by the
// single read port of the line store walked once per window entry and the 16-cell divider
// chain. Results appear RADIUS rows plus RADIUS samples after their input.
// Reset clears positions, counters and handshake state; the line store is not cleared.
module masked_box_mean_filter #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned RADIUS    = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mbmf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mbmf_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import mbmf_pkg::*;

  localparam int unsigned Ring  = 3 * RADIUS + 1;
  localparam int unsigned Side  = 2 * RADIUS + 1;
  localparam int unsigned WinN  = Side * Side;
  localparam int unsigned Depth = Ring * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW    = $clog2(Ring);
  localparam int unsigned DW    = $clog2(Side);
  localparam int unsigned NW    = $clog2(WinN + 1);
  localparam int unsigned SUMW  = SampleW + $clog2(WinN);
  localparam int unsigned PW    = $clog2(RADIUS * MAX_WIDTH + RADIUS + 2);

  // configuration
  logic [10:0]        cfg_width_q;
  logic [15:0]        cfg_height_q, cfg_miss_q, cfg_bad_q;
  logic [WW-1:0]      weff;
  logic [15:0]        heff;
  logic [PW-1:0]      lag;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= 11'd1024;
      cfg_height_q <= 16'd1024;
      cfg_miss_q   <= '0;
      cfg_bad_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_WIDTH:   cfg_width_q  <= cfg_data_i[10:0];
        CFG_HEIGHT:  cfg_height_q <= cfg_data_i;
        CFG_MISSING: cfg_miss_q   <= cfg_data_i;
        CFG_BAD:     cfg_bad_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_q == '0) begin
      weff = WW'(1);
    end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(cfg_width_q);
    end
    heff = (cfg_height_q == '0) ? 16'd1 : cfg_height_q;
    lag  = PW'(32'(RADIUS) * 32'(weff) + 32'(RADIUS));
  end

  // control and positions
  state_e          state_q, state_d;
  logic [CW-1:0]   in_col_q, in_col_d, out_col_q, out_col_d;
  logic [15:0]     in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SW-1:0]   in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic [PW-1:0]   pend_q, pend_d;
  logic [DW-1:0]   dr_q, dr_d, dc_q, dc_d;
  logic            accept, is_sample, emit, load_out, last_tap;

  // window walk and accumulation
  logic [SUMW-1:0]    sum_q, sum_d;
  logic [NW-1:0]      num_q, num_d;
  logic [SampleW-1:0] centre_q, centre_d, rd_q, res_q;
  logic               tag_v_q, tag_c_q, rd_en, rd_centre, take;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [CW+1:0]      cs;
  logic [16:0]        rs;
  logic [SW+3:0]      slot_s;
  logic [SW-1:0]      rd_slot;

  logic [SampleW-1:0] mem [Depth];

  // divider chain
  logic               dv   [SampleW+1];
  logic [NW-1:0]      drem [SampleW+1];
  logic [SampleW-1:0] dwrd [SampleW+1];
  logic [NW-1:0]      dnum [SampleW+1];

  out_item_t out_q;
  logic      out_valid_q;

  assign accept    = in_valid_i && !in_stall_o;
  assign is_sample = (in_item_i.action == ACT_SAMPLE);
  assign last_tap  = (dr_q == DW'(Side - 1)) && (dc_q == DW'(Side - 1));
  assign load_out  = (state_q == ST_PUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (is_sample) begin
      emit = (PW'(pend_q + PW'(1)) > lag);
    end else begin
      emit = (in_col_q == '0) && (in_row_q == '0) && (pend_q != '0);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && emit) state_d = ST_WALK;
      ST_WALK: if (last_tap) state_d = ST_LAST;
      ST_LAST: state_d = ST_DIV;
      ST_DIV:  if (dv[SampleW]) state_d = ST_PUT;
      ST_PUT:  if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    take       = (state_q == ST_WALK) || (state_q == ST_LAST);
  end

  // tap address of the current window entry
  always_comb begin
    cs        = (CW+2)'(out_col_q) + (CW+2)'(dc_q);
    rs        = 17'(out_row_q) + 17'(dr_q);
    rd_en     = (state_q == ST_WALK)
             && (cs >= (CW+2)'(RADIUS)) && (cs < (CW+2)'(weff) + (CW+2)'(RADIUS))
             && (rs >= 17'(RADIUS)) && (rs < 17'(heff) + 17'(RADIUS));
    rd_centre = (dr_q == DW'(RADIUS)) && (dc_q == DW'(RADIUS));
    slot_s    = (SW+4)'(out_slot_q) + (SW+4)'(dr_q) + (SW+4)'(Ring - RADIUS);
    if (slot_s >= (SW+4)'(2 * Ring)) begin
      rd_slot = SW'(slot_s - (SW+4)'(2 * Ring));
    end else if (slot_s >= (SW+4)'(Ring)) begin
      rd_slot = SW'(slot_s - (SW+4)'(Ring));
    end else begin
      rd_slot = SW'(slot_s);
    end
    rd_addr = AW'(32'(rd_slot) * MAX_WIDTH + 32'(CW'(cs - (CW+2)'(RADIUS))));
    wr_addr = AW'(32'(in_slot_q) * MAX_WIDTH + 32'(in_col_q));
  end

  // accumulate the tap read in the previous cycle
  always_comb begin
    sum_d    = sum_q;
    num_d    = num_q;
    centre_d = centre_q;
    if (tag_v_q) begin
      if (rd_q != cfg_miss_q && rd_q != cfg_bad_q) begin
        sum_d = sum_q + SUMW'(rd_q);
        num_d = num_q + NW'(1);
      end
      if (tag_c_q) centre_d = rd_q;
    end
  end

  // position counters
  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    pend_d     = pend_q;
    dr_d       = dr_q;
    dc_d       = dc_q;
    if (accept && is_sample) begin
      pend_d = PW'(pend_q + PW'(1));
      if ((WW+1)'(in_col_q) + (WW+1)'(1) >= (WW+1)'(weff)) begin
        in_col_d  = '0;
        in_row_d  = (17'(in_row_q) + 17'd1 >= 17'(heff)) ? 16'd0 : 16'(in_row_q + 16'd1);
        in_slot_d = (in_slot_q == SW'(Ring - 1)) ? '0 : SW'(in_slot_q + SW'(1));
      end else begin
        in_col_d = CW'(in_col_q + CW'(1));
      end
    end
    if (accept) begin
      dr_d = '0;
      dc_d = '0;
    end else if (state_q == ST_WALK) begin
      if (dc_q == DW'(Side - 1)) begin
        dc_d = '0;
        dr_d = DW'(dr_q + DW'(1));
      end else begin
        dc_d = DW'(dc_q + DW'(1));
      end
    end
    if (load_out) begin
      if (accept) pend_d = pend_q;
      else        pend_d = PW'(pend_q - PW'(1));
      if ((WW+1)'(out_col_q) + (WW+1)'(1) >= (WW+1)'(weff)) begin
        out_col_d  = '0;
        out_row_d  = (17'(out_row_q) + 17'd1 >= 17'(heff)) ? 16'd0 : 16'(out_row_q + 16'd1);
        out_slot_d = (out_slot_q == SW'(Ring - 1)) ? '0 : SW'(out_slot_q + SW'(1));
      end else begin
        out_col_d = CW'(out_col_q + CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      pend_q      <= '0;
      dr_q        <= '0;
      dc_q        <= '0;
      tag_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      num_q       <= '0;
    end else begin
      state_q     <= state_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      in_slot_q   <= in_slot_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_slot_q  <= out_slot_d;
      pend_q      <= pend_d;
      dr_q        <= dr_d;
      dc_q        <= dc_d;
      tag_v_q     <= rd_en;
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
      if (accept) begin
        sum_q <= '0;
        num_q <= '0;
      end else if (take) begin
        sum_q <= sum_d;
        num_q <= num_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_c_q <= rd_centre;
    if (take) centre_q <= centre_d;
    if (accept && is_sample) mem[wr_addr] <= in_item_i.sample;
    if (rd_en) rd_q <= mem[rd_addr];
    if (state_q == ST_DIV && dv[SampleW]) begin
      res_q <= (num_q == '0) ? centre_q : dwrd[SampleW];
    end
    if (load_out) begin
      out_q.smoothed  <= res_q;
      out_q.frame_end <= (out_row_q == 16'(heff - 16'd1))
                      && ((WW+1)'(out_col_q) + (WW+1)'(1) == (WW+1)'(weff));
    end
  end

  // divider chain fed with the finished window sum
  assign dv[0]   = (state_q == ST_LAST);
  assign drem[0] = NW'(sum_d >> SampleW);
  assign dwrd[0] = sum_d[SampleW-1:0];
  assign dnum[0] = num_d;

  for (genvar g = 0; g < SampleW; g++) begin : g_div
    mbmf_div_cell #(.NUM_W(NW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[g]),
      .rem_i   (drem[g]),
      .word_i  (dwrd[g]),
      .num_i   (dnum[g]),
      .valid_o (dv[g+1]),
      .rem_o   (drem[g+1]),
      .word_o  (dwrd[g+1]),
      .num_o   (dnum[g+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // the chain only returns a quotient while the sequencer waits for it
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[SampleW] |-> state_q == ST_DIV)
    else $error("divider result outside wait state");

  // a flush with nothing pending gives no work
  a_flush_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_sample && pend_q == '0) |=> state_q == ST_IDLE)
    else $error("empty flush started a window walk");

  // the valid count never exceeds the window size
  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(num_q) <= WinN)
    else $error("window count overflow");

endmodule
